### sv/bpa_pkg.sv
package bpa_pkg;

    localparam int PAGE_W   = 14;
    localparam int ORDER_W  = 4;
    localparam int STATUS_W = 2;
    localparam int BC_W     = 5;
    localparam int RSV_W    = 15;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam int PAGE_COUNT = 16384;
    localparam int TOP_ORDER  = 10;

    localparam logic [BC_W-1:0]  BC_RESET  = 5'd16;
    localparam logic [RSV_W-1:0] RSV_RESET = 15'd0;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic REG_BLOCK_COUNT    = 1'b0;
    localparam logic REG_RESERVED_PAGES = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

endpackage

### sv/bpa_if.sv
interface bpa_req_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [bpa_pkg::ORDER_W-1:0]  order;
    logic [bpa_pkg::PAGE_W-1:0]   page_index;

    modport source (output valid, mode, order, page_index, input ready);
    modport sink   (input valid, mode, order, page_index, output ready);
endinterface

interface bpa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bpa_pkg::PAGE_W-1:0]    result_page;
    logic [bpa_pkg::ORDER_W-1:0]   result_order;
    logic [bpa_pkg::STATUS_W-1:0]  status;

    modport source (output valid, result_page, result_order, status, input ready);
    modport sink   (input valid, result_page, result_order, status, output ready);
endinterface

### sv/buddy_page_allocator.sv
// allocate: searches orders upward from the requested one, then splits the block down to it
// free: checks the page, then merges with each free buddy of equal order, then appends the block
// too large an order, a page out of range and a free of an unused page answer without a search
// one word at a time; ready again in the same cycle as the result is presented, unless it stalls
// after reset and after every register write a clearing pass over all 16384 pages rebuilds the lists
// reset is asynchronous, active low; registers return to block_count 16, reserved 0
module buddy_page_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpa_pkg::APB_AW-1:0]   paddr,
    input  logic [bpa_pkg::APB_DW-1:0]   pwdata,
    output logic [bpa_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    bpa_req_if.sink                      req,
    bpa_rsp_if.source                    rsp
);

    localparam int PAGES     = bpa_pkg::PAGE_COUNT;
    localparam int TOP_ORDER = bpa_pkg::TOP_ORDER;
    localparam int PW  = $clog2(PAGES);
    localparam int OW  = $clog2(TOP_ORDER + 1);
    localparam int CW  = OW + 1;
    localparam int BLK = 1 << TOP_ORDER;
    localparam int XA  = (PW + 2 > TOP_ORDER + 6) ? PW + 2 : TOP_ORDER + 6;
    localparam int XW  = (XA > 17) ? XA : 17;

    typedef struct packed {
        logic [OW-1:0] ord;
        logic          in_use;
        logic          free_head;
    } meta_t;

    typedef enum logic [13:0] {
        S_INIT  = 14'b00000000000001,
        S_IDLE  = 14'b00000000000010,
        S_ASRCH = 14'b00000000000100,
        S_AHEAD = 14'b00000000001000,
        S_AREM  = 14'b00000000010000,
        S_SPLIT = 14'b00000000100000,
        S_APP1  = 14'b00000001000000,
        S_APP2  = 14'b00000010000000,
        S_FCHK  = 14'b00000100000000,
        S_FBUD  = 14'b00001000000000,
        S_FBCHK = 14'b00010000000000,
        S_FREM2 = 14'b00100000000000,
        S_DONE  = 14'b01000000000000,
        S_SPARE = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [bpa_pkg::BC_W-1:0]  bc_reg, bc_next;
    logic [bpa_pkg::RSV_W-1:0] rsv_reg, rsv_next;

    logic [PW-1:0] init_cnt_reg, init_cnt_next;
    logic [PW-1:0] idx_reg, idx_next;
    logic [PW-1:0] bud_reg, bud_next;
    logic [PW-1:0] app_pg_reg, app_pg_next;
    logic [CW-1:0] ord_reg, ord_next;
    logic [OW-1:0] req_ord_reg, req_ord_next;
    logic          mode_reg, mode_next;

    logic [PW-1:0]                 res_page_reg, res_page_next;
    logic [bpa_pkg::ORDER_W-1:0]   res_order_reg, res_order_next;
    logic [bpa_pkg::STATUS_W-1:0]  res_status_reg, res_status_next;

    logic                          out_valid_reg, out_valid_next;
    logic [bpa_pkg::PAGE_W-1:0]    out_page_reg, out_page_next;
    logic [bpa_pkg::ORDER_W-1:0]   out_order_reg, out_order_next;
    logic [bpa_pkg::STATUS_W-1:0]  out_status_reg, out_status_next;

    logic [PW-1:0]      head_reg [TOP_ORDER+1];
    logic [PW-1:0]      head_next [TOP_ORDER+1];
    logic [PW-1:0]      tail_reg [TOP_ORDER+1];
    logic [PW-1:0]      tail_next [TOP_ORDER+1];
    logic [TOP_ORDER:0] used_reg, used_next;

    logic [PW-1:0] next_mem [PAGES];
    logic [PW-1:0] prev_mem [PAGES];
    meta_t         meta_mem [PAGES];

    logic          next_we, prev_we, meta_we;
    logic [PW-1:0] next_wa, prev_wa, meta_wa;
    logic [PW-1:0] next_wd, prev_wd;
    meta_t         meta_wd;
    logic [PW-1:0] next_ra, prev_ra, meta_ra;
    logic [PW-1:0] next_rd_reg, prev_rd_reg;
    meta_t         meta_rd_reg;

    logic          cfg_we;
    logic [XW-1:0] total_w, managed_w, first_w, rlim_w, ix_w;
    logic          is_blk_w;
    logic [OW-1:0] ol;
    logic [CW-1:0] ord_dec;
    logic [PW-1:0] bud_w;
    logic [PW-1:0] nx, pv;
    logic          first_hit, last_hit;

    assign cfg_we  = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign prdata  = (paddr[2] == bpa_pkg::REG_RESERVED_PAGES)
                   ? {{(bpa_pkg::APB_DW - bpa_pkg::RSV_W){1'b0}}, rsv_reg}
                   : {{(bpa_pkg::APB_DW - bpa_pkg::BC_W){1'b0}}, bc_reg};

    assign total_w   = XW'(bc_reg) << TOP_ORDER;
    assign managed_w = (total_w > XW'(PAGES)) ? XW'(PAGES) : total_w;
    assign first_w   = ((XW'(rsv_reg) + XW'(BLK - 1)) >> TOP_ORDER) << TOP_ORDER;
    assign rlim_w    = (XW'(rsv_reg) < managed_w) ? XW'(rsv_reg) : managed_w;
    assign ix_w      = XW'(init_cnt_reg);
    assign is_blk_w  = ((ix_w & XW'(BLK - 1)) == '0) && (ix_w >= first_w)
                    && (ix_w + XW'(BLK) <= managed_w);

    assign ol      = ord_reg[OW-1:0];
    assign ord_dec = ord_reg - CW'(1);
    assign bud_w   = idx_reg ^ (PW'(1) << ord_reg);
    assign nx      = next_rd_reg;
    assign pv      = prev_rd_reg;

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.result_page  = out_page_reg;
    assign rsp.result_order = out_order_reg;
    assign rsp.status       = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        bc_next         = bc_reg;
        rsv_next        = rsv_reg;
        init_cnt_next   = init_cnt_reg;
        idx_next        = idx_reg;
        bud_next        = bud_reg;
        app_pg_next     = app_pg_reg;
        ord_next        = ord_reg;
        req_ord_next    = req_ord_reg;
        mode_next       = mode_reg;
        res_page_next   = res_page_reg;
        res_order_next  = res_order_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_page_next   = out_page_reg;
        out_order_next  = out_order_reg;
        out_status_next = out_status_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        used_next       = used_reg;
        first_hit       = (head_reg[ol] == bud_reg);
        last_hit        = (tail_reg[ol] == bud_reg);

        next_we = 1'b0;
        next_wa = '0;
        next_wd = '0;
        prev_we = 1'b0;
        prev_wa = '0;
        prev_wd = '0;
        meta_we = 1'b0;
        meta_wa = '0;
        meta_wd = '0;
        next_ra = idx_reg;
        prev_ra = idx_reg;
        meta_ra = req.page_index[PW-1:0];

        unique case (state_reg)
            S_INIT:
            begin
                meta_we = 1'b1;
                meta_wa = init_cnt_reg;
                meta_wd.ord       = is_blk_w ? OW'(TOP_ORDER) : '0;
                meta_wd.in_use    = (ix_w < rlim_w);
                meta_wd.free_head = is_blk_w;
                next_we = 1'b1;
                next_wa = init_cnt_reg;
                next_wd = (is_blk_w && (ix_w + XW'(2 * BLK) <= managed_w))
                        ? PW'(ix_w + XW'(BLK)) : '0;
                prev_we = 1'b1;
                prev_wa = init_cnt_reg;
                prev_wd = (is_blk_w && (ix_w > first_w)) ? PW'(ix_w - XW'(BLK)) : '0;
                if (is_blk_w)
                begin
                    if (!used_reg[TOP_ORDER])
                    begin
                        head_next[TOP_ORDER] = init_cnt_reg;
                        used_next[TOP_ORDER] = 1'b1;
                    end
                    tail_next[TOP_ORDER] = init_cnt_reg;
                end
                if (init_cnt_reg == PW'(PAGES - 1))
                    state_next = S_IDLE;
                else
                    init_cnt_next = init_cnt_reg + PW'(1);
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    mode_next       = req.mode;
                    idx_next        = req.page_index[PW-1:0];
                    res_page_next   = '0;
                    res_order_next  = '0;
                    res_status_next = bpa_pkg::ST_OK;
                    if (req.mode == bpa_pkg::MODE_ALLOC)
                    begin
                        if (XW'(req.order) > XW'(TOP_ORDER))
                        begin
                            res_status_next = bpa_pkg::ST_OOM;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            ord_next     = CW'(req.order);
                            req_ord_next = OW'(req.order);
                            state_next   = S_ASRCH;
                        end
                    end
                    else if (XW'(req.page_index) >= managed_w)
                    begin
                        res_status_next = bpa_pkg::ST_INVALID;
                        state_next      = S_DONE;
                    end
                    else
                        state_next = S_FCHK;
                end
            end

            S_ASRCH:
            begin
                if (used_reg[ol])
                begin
                    idx_next   = head_reg[ol];
                    state_next = S_AHEAD;
                end
                else if (ord_reg >= CW'(TOP_ORDER))
                begin
                    res_status_next = bpa_pkg::ST_OOM;
                    state_next      = S_DONE;
                end
                else
                    ord_next = ord_reg + CW'(1);
            end

            S_AHEAD:
            begin
                state_next = S_AREM;
            end

            S_AREM:
            begin
                if (tail_reg[ol] == idx_reg)
                begin
                    used_next[ol] = 1'b0;
                    head_next[ol] = '0;
                    tail_next[ol] = '0;
                end
                else
                begin
                    head_next[ol] = nx;
                    prev_we = 1'b1;
                    prev_wa = nx;
                    prev_wd = '0;
                end
                next_we = 1'b1;
                next_wa = idx_reg;
                next_wd = '0;
                meta_we = 1'b1;
                meta_wa = idx_reg;
                meta_wd.ord       = req_ord_reg;
                meta_wd.in_use    = 1'b1;
                meta_wd.free_head = 1'b0;
                state_next = S_SPLIT;
            end

            S_SPLIT:
            begin
                if (ord_reg > CW'(req_ord_reg))
                begin
                    ord_next    = ord_dec;
                    app_pg_next = idx_reg + (PW'(1) << ord_dec);
                    state_next  = S_APP1;
                end
                else
                begin
                    res_page_next  = idx_reg;
                    res_order_next = bpa_pkg::ORDER_W'(req_ord_reg);
                    state_next     = S_DONE;
                end
            end

            S_APP1:
            begin
                meta_we = 1'b1;
                meta_wa = app_pg_reg;
                meta_wd.ord       = ol;
                meta_wd.in_use    = 1'b0;
                meta_wd.free_head = 1'b1;
                prev_we = 1'b1;
                prev_wa = app_pg_reg;
                if (used_reg[ol])
                begin
                    next_we = 1'b1;
                    next_wa = tail_reg[ol];
                    next_wd = app_pg_reg;
                    prev_wd = tail_reg[ol];
                end
                else
                begin
                    prev_wd       = '0;
                    head_next[ol] = app_pg_reg;
                    used_next[ol] = 1'b1;
                end
                tail_next[ol] = app_pg_reg;
                state_next    = S_APP2;
            end

            S_APP2:
            begin
                next_we = 1'b1;
                next_wa = app_pg_reg;
                next_wd = '0;
                if (mode_reg == bpa_pkg::MODE_FREE)
                begin
                    res_page_next  = app_pg_reg;
                    res_order_next = bpa_pkg::ORDER_W'(ord_reg);
                    state_next     = S_DONE;
                end
                else
                    state_next = S_SPLIT;
            end

            S_FCHK:
            begin
                if (!meta_rd_reg.in_use)
                begin
                    res_status_next = bpa_pkg::ST_INVALID;
                    state_next      = S_DONE;
                end
                else
                begin
                    ord_next = CW'(meta_rd_reg.ord);
                    meta_we  = 1'b1;
                    meta_wa  = idx_reg;
                    meta_wd  = '0;
                    state_next = S_FBUD;
                end
            end

            S_FBUD:
            begin
                next_ra = bud_w;
                prev_ra = bud_w;
                meta_ra = bud_w;
                bud_next = bud_w;
                if (ord_reg >= CW'(TOP_ORDER) || XW'(bud_w) >= managed_w)
                begin
                    app_pg_next = idx_reg;
                    state_next  = S_APP1;
                end
                else
                    state_next = S_FBCHK;
            end

            S_FBCHK:
            begin
                if (!meta_rd_reg.free_head || meta_rd_reg.ord != ol)
                begin
                    app_pg_next = idx_reg;
                    state_next  = S_APP1;
                end
                else
                begin
                    if (first_hit && last_hit)
                    begin
                        used_next[ol] = 1'b0;
                        head_next[ol] = '0;
                        tail_next[ol] = '0;
                    end
                    else if (first_hit)
                    begin
                        head_next[ol] = nx;
                        prev_we = 1'b1;
                        prev_wa = nx;
                        prev_wd = '0;
                    end
                    else if (last_hit)
                    begin
                        tail_next[ol] = pv;
                        next_we = 1'b1;
                        next_wa = pv;
                        next_wd = '0;
                    end
                    else
                    begin
                        next_we = 1'b1;
                        next_wa = pv;
                        next_wd = nx;
                        prev_we = 1'b1;
                        prev_wa = nx;
                        prev_wd = pv;
                    end
                    meta_we = 1'b1;
                    meta_wa = bud_reg;
                    meta_wd = '0;
                    state_next = S_FREM2;
                end
            end

            S_FREM2:
            begin
                next_we = 1'b1;
                next_wa = bud_reg;
                next_wd = '0;
                prev_we = 1'b1;
                prev_wa = bud_reg;
                prev_wd = '0;
                if (bud_reg < idx_reg)
                    idx_next = bud_reg;
                ord_next   = ord_reg + CW'(1);
                state_next = S_FBUD;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_page_next   = bpa_pkg::PAGE_W'(res_page_reg);
                    out_order_next  = res_order_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            if (paddr[2] == bpa_pkg::REG_BLOCK_COUNT)
                bc_next = pwdata[bpa_pkg::BC_W-1:0];
            else
                rsv_next = pwdata[bpa_pkg::RSV_W-1:0];
            state_next    = S_INIT;
            init_cnt_next = '0;
            used_next     = '0;
            for (int k = 0; k <= TOP_ORDER; k++)
            begin
                head_next[k] = '0;
                tail_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            bc_reg        <= bpa_pkg::BC_RESET;
            rsv_reg       <= bpa_pkg::RSV_RESET;
            init_cnt_reg  <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k <= TOP_ORDER; k++)
            begin
                head_reg[k] <= '0;
                tail_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            bc_reg        <= bc_next;
            rsv_reg       <= rsv_next;
            init_cnt_reg  <= init_cnt_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        bud_reg        <= bud_next;
        app_pg_reg     <= app_pg_next;
        ord_reg        <= ord_next;
        req_ord_reg    <= req_ord_next;
        mode_reg       <= mode_next;
        res_page_reg   <= res_page_next;
        res_order_reg  <= res_order_next;
        res_status_reg <= res_status_next;
        out_page_reg   <= out_page_next;
        out_order_reg  <= out_order_next;
        out_status_reg <= out_status_next;
    end

    // link and page memories
    always_ff @(posedge clk)
    begin
        if (next_we)
            next_mem[next_wa] <= next_wd;
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        if (meta_we)
            meta_mem[meta_wa] <= meta_wd;
        next_rd_reg <= next_mem[next_ra];
        prev_rd_reg <= prev_mem[prev_ra];
        meta_rd_reg <= meta_mem[meta_ra];
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && (!out_valid_reg || rsp.ready))
        |=> (rsp.valid && state_reg == S_IDLE))
        else $error("finished word not presented");

    assert property (@(posedge clk) disable iff (!rst_n)
        !used_reg[TOP_ORDER] && state_reg != S_INIT
        |-> (head_reg[TOP_ORDER] == '0 && tail_reg[TOP_ORDER] == '0))
        else $error("empty list keeps stale ends");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != bpa_pkg::ST_OK)
        |-> (rsp.result_page == '0 && rsp.result_order == '0))
        else $error("error word carries a page");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we) |=> (state_reg == S_INIT && !req.ready))
        else $error("register write did not start rebuild");

endmodule
